@@ hdl/fdmd_pkg.sv @@
// Shared constants and types for the frame-difference motion detector.
// No dependencies.
package fdmd_pkg;
  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int AddrW     = ColW + RowW;
  localparam int CntW      = 21;

  localparam logic [2:0] RegWidth  = 3'd0;
  localparam logic [2:0] RegHeight = 3'd1;
  localparam logic [2:0] RegThresh = 3'd2;
  localparam logic [2:0] RegStart  = 3'd3;
  localparam logic [2:0] RegEnd    = 3'd4;
  localparam logic [2:0] RegPixTh  = 3'd5;

  typedef struct packed {
    logic [10:0] line_len;
    logic [10:0] line_count;
    logic [13:0] share_thresh;
    logic [7:0]  start_frames;
    logic [7:0]  end_frames;
    logic [7:0]  pixel_threshold;
  } cfg_t;

  typedef struct packed {
    logic [31:0] frame_number;
    logic        first_frame;
    logic [20:0] changed_count;
    logic        motion_now;
    logic        motion_state;
    logic        motion_rise;
    logic        motion_fall;
  } result_t;

  // Effective size: zero reads as one, large values clamp to the maximum.
  function automatic logic [10:0] eff_size(input logic [10:0] v, input logic [10:0] maxv);
    logic [10:0] r;
    r = v;
    if (v == 11'd0) r = 11'd1;
    else if (v > maxv) r = maxv;
    return r;
  endfunction
endpackage

@@ hdl/fdmd_if.sv @@
// Valid/ready channel interfaces for input pixels and frame results.
// Depends on fdmd_pkg.
interface fdmd_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma;
  modport source (output valid, output luma, input ready);
  modport sink   (input valid, input luma, output ready);
endinterface

interface fdmd_res_if;
  logic              valid;
  logic              ready;
  fdmd_pkg::result_t res;
  modport source (output valid, output res, input ready);
  modport sink   (input valid, input res, output ready);
endinterface

@@ hdl/fdmd_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// No dependencies.
module fdmd_ram #(
  parameter int DW = 8,
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ hdl/fdmd_core.sv @@
// Frame engine: stores frames, then sweeps the planes at frame end (diff, blur,
// erode, dilate) with memories, and counts marks. Depends on fdmd_pkg, fdmd_ram.
module fdmd_core (
  input  logic              clk,
  input  logic              rst_n,
  input  fdmd_pkg::cfg_t    cfg,
  input  logic              size_wr,
  input  logic              pix_valid,
  output logic              pix_ready,
  input  logic [7:0]        pix_luma,
  output logic              done,
  output logic              first,
  output logic [20:0]       count
);
  localparam int AW = fdmd_pkg::AddrW;
  localparam int CW = fdmd_pkg::ColW;
  localparam int RW = fdmd_pkg::RowW;

  typedef enum logic [2:0] {S_RUN, S_DIFF, S_BLUR, S_ERO, S_DIL, S_DONE} state_t;

  typedef enum logic [2:0] {P_IDLE, P_ISSUE, P_CAPT} phase_t;

  state_t state_r;
  phase_t ph_r;
  logic [CW:0] col_r;
  logic [RW:0] row_r;
  logic        have_prev_r;
  logic [20:0] cnt_r;
  logic [CW:0] sx_r;
  logic [RW:0] sy_r;
  logic [2:0]  tx_r, ty_r;
  logic [18:0] acc_r;

  logic [10:0] w, h;
  assign w = fdmd_pkg::eff_size(cfg.line_len, 11'(fdmd_pkg::MaxWidth));
  assign h = fdmd_pkg::eff_size(cfg.line_count, 11'(fdmd_pkg::MaxHeight));

  // memories: current, previous, diff, mark, eroded
  logic          cur_we, prev_we, dif_we, mrk_we, ero_we;
  logic [AW-1:0] cur_wa, prev_wa, dif_wa, mrk_wa, ero_wa, ra;
  logic [7:0]    cur_wd, prev_wd, dif_wd, cur_rd, prev_rd, dif_rd;
  logic [0:0]    mrk_wd, ero_wd, mrk_rd, ero_rd;

  fdmd_ram #(.DW(8), .AW(AW)) u_cur  (.clk, .we(cur_we),  .waddr(cur_wa),  .wdata(cur_wd),
                                       .raddr(ra), .rdata(cur_rd));
  fdmd_ram #(.DW(8), .AW(AW)) u_prev (.clk, .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
                                       .raddr(ra), .rdata(prev_rd));
  fdmd_ram #(.DW(8), .AW(AW)) u_dif  (.clk, .we(dif_we),  .waddr(dif_wa),  .wdata(dif_wd),
                                       .raddr(ra), .rdata(dif_rd));
  fdmd_ram #(.DW(1), .AW(AW)) u_mrk  (.clk, .we(mrk_we),  .waddr(mrk_wa),  .wdata(mrk_wd),
                                       .raddr(ra), .rdata(mrk_rd));
  fdmd_ram #(.DW(1), .AW(AW)) u_ero  (.clk, .we(ero_we),  .waddr(ero_wa),  .wdata(ero_wd),
                                       .raddr(ra), .rdata(ero_rd));

  assign pix_ready = (state_r == S_RUN) && !size_wr;

  // Column/row wrap for the frame position (out-of-range restarts).
  logic [CW:0] pc;
  logic [RW:0] pr;
  always_comb begin
    pc = col_r; pr = row_r;
    if ({1'b0, col_r} >= {1'b0, w} || {1'b0, row_r} >= {1'b0, h}) begin
      pc = '0; pr = '0;
    end
  end

  // Tap offsets for blur (5x5) and morphology (3x3)
  logic signed [3:0] dx, dy;
  logic [2:0] wgt_x, wgt_y;
  logic [2:0] tap_max;
  always_comb begin
    if (state_r == S_BLUR) begin
      dx = signed'({1'b0, tx_r}) - 4'sd2;
      dy = signed'({1'b0, ty_r}) - 4'sd2;
      tap_max = 3'd4;
    end else begin
      dx = signed'({1'b0, tx_r}) - 4'sd1;
      dy = signed'({1'b0, ty_r}) - 4'sd1;
      tap_max = 3'd2;
    end
  end

  function automatic logic [2:0] binom(input logic signed [3:0] d);
    logic [2:0] r;
    case (d)
      -4'sd2, 4'sd2: r = 3'd1;
      -4'sd1, 4'sd1: r = 3'd4;
      default:       r = 3'd6;
    endcase
    return r;
  endfunction
  assign wgt_x = binom(dx);
  assign wgt_y = binom(dy);

  // Neighbor coordinates, mirrored for blur, flagged out-of-range for morphology
  logic signed [12:0] nx, ny, mx, my, ws, hs;
  logic inside_f;
  assign ws = 13'(w);
  assign hs = 13'(h);
  always_comb begin
    nx = 13'(signed'({1'b0, sx_r})) + 13'(dx);
    ny = 13'(signed'({1'b0, sy_r})) + 13'(dy);
    mx = nx; my = ny;
    if (w == 11'd1) mx = '0;
    else begin
      if (mx < 0) mx = -mx;
      if (mx >= ws) mx = ws + ws - 13'sd2 - mx;
      if (mx < 0) mx = -mx;
    end
    if (h == 11'd1) my = '0;
    else begin
      if (my < 0) my = -my;
      if (my >= hs) my = hs + hs - 13'sd2 - my;
      if (my < 0) my = -my;
    end
    inside_f = (nx >= 0) && (ny >= 0) && (nx < ws) && (ny < hs);
  end

  logic [AW-1:0] sweep_a;
  assign sweep_a = {sy_r[RW-1:0], sx_r[CW-1:0]};

  always_comb begin
    case (state_r)
      S_BLUR:       ra = {my[RW-1:0], mx[CW-1:0]};
      S_ERO, S_DIL: ra = inside_f ? {ny[RW-1:0], nx[CW-1:0]} : sweep_a;
      default:      ra = sweep_a;
    endcase
  end

  logic inside_d_r;
  logic [5:0] wprod_r;
  logic last_tap;
  assign last_tap = (state_r == S_DIFF) || ((tx_r == tap_max) && (ty_r == tap_max));

  logic [7:0] adiff;
  assign adiff = (cur_rd > prev_rd) ? cur_rd - prev_rd : prev_rd - cur_rd;
  logic [18:0] acc_new;
  assign acc_new = acc_r + 19'(wprod_r) * 19'(dif_rd);
  logic [10:0] blur_v;
  assign blur_v = 11'((acc_new + 19'd128) >> 8);
  logic morph_new;
  assign morph_new = (state_r == S_ERO) ? (acc_r[0] & (~inside_d_r | mrk_rd[0]))
                                        : (acc_r[0] | (inside_d_r & ero_rd[0]));

  always_comb begin
    cur_we = 1'b0; cur_wa = {pr[RW-1:0], pc[CW-1:0]}; cur_wd = pix_luma;
    prev_we = 1'b0; prev_wa = sweep_a; prev_wd = cur_rd;
    dif_we = 1'b0; dif_wa = sweep_a; dif_wd = adiff;
    mrk_we = 1'b0; mrk_wa = sweep_a; mrk_wd = 1'(blur_v > 11'(cfg.pixel_threshold));
    ero_we = 1'b0; ero_wa = sweep_a; ero_wd = morph_new;
    if (pix_valid && pix_ready) cur_we = 1'b1;
    if (ph_r == P_CAPT) begin
      case (state_r)
        S_DIFF:  begin dif_we = 1'b1; prev_we = 1'b1; end
        S_BLUR:  mrk_we = last_tap;
        S_ERO:   ero_we = last_tap;
        default: ;
      endcase
    end
  end

  // Last pixel of the sweep
  logic sw_end;
  assign sw_end = ({1'b0, sx_r} == {1'b0, w} - 12'd1) && ({1'b0, sy_r} == {1'b0, h} - 12'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN; ph_r <= P_IDLE; col_r <= '0; row_r <= '0;
      have_prev_r <= 1'b0; cnt_r <= '0; done <= 1'b0; first <= 1'b0;
      sx_r <= '0; sy_r <= '0; tx_r <= '0; ty_r <= '0; acc_r <= '0; inside_d_r <= 1'b0;
      wprod_r <= '0; count <= '0;
    end else begin
      done <= 1'b0;
      unique case (state_r)
        S_RUN: begin
          if (size_wr) begin
            col_r <= '0; row_r <= '0;
          end else if (pix_valid) begin
            if ({1'b0, pc} + 12'd1 < {1'b0, w}) begin
              col_r <= pc + 1'b1; row_r <= pr;
            end else if ({1'b0, pr} + 12'd1 < {1'b0, h}) begin
              col_r <= '0; row_r <= pr + 1'b1;
            end else begin
              col_r <= '0; row_r <= '0;
              sx_r <= '0; sy_r <= '0; tx_r <= '0; ty_r <= '0; cnt_r <= '0;
              ph_r <= P_ISSUE; acc_r <= '0;
              state_r <= S_DIFF;
              first <= !have_prev_r;
            end
          end
        end
        S_DIFF, S_BLUR, S_ERO, S_DIL: begin
          if (ph_r == P_ISSUE) begin
            inside_d_r <= inside_f;
            wprod_r <= 6'(wgt_x) * 6'(wgt_y);
            ph_r <= P_CAPT;
          end else begin
            ph_r <= P_ISSUE;
            if (!last_tap) begin
              if (tx_r == tap_max) begin
                tx_r <= '0; ty_r <= ty_r + 3'd1;
              end else begin
                tx_r <= tx_r + 3'd1;
              end
              acc_r <= (state_r == S_BLUR) ? acc_new : {18'd0, morph_new};
            end else begin
              tx_r <= '0; ty_r <= '0;
              if (state_r == S_DIL) cnt_r <= cnt_r + 21'(morph_new);
              if (sw_end) begin
                sx_r <= '0; sy_r <= '0;
                // erode starts from all-set, blur and dilate from zero
                unique case (state_r)
                  S_DIFF:  begin state_r <= first ? S_DONE : S_BLUR; acc_r <= '0; end
                  S_BLUR:  begin state_r <= S_ERO; acc_r <= 19'd1; end
                  S_ERO:   begin state_r <= S_DIL; acc_r <= '0; end
                  default: begin state_r <= S_DONE; acc_r <= '0; end
                endcase
              end else begin
                acc_r <= (state_r == S_ERO) ? 19'd1 : 19'd0;
                if ({1'b0, sx_r} + 12'd1 < {1'b0, w}) begin
                  sx_r <= sx_r + 1'b1;
                end else begin
                  sx_r <= '0; sy_r <= sy_r + 1'b1;
                end
              end
            end
          end
        end
        S_DONE: begin
          count <= first ? 21'd0 : cnt_r;
          have_prev_r <= 1'b1;
          done <= 1'b1;
          ph_r <= P_IDLE;
          state_r <= S_RUN;
        end
        default: state_r <= S_RUN;
      endcase
    end
  end
endmodule

@@ hdl/fdmd_decide.sv @@
// Frame decision: share test, hysteresis run counters, result register.
// Depends on fdmd_pkg, fdmd_if.
module fdmd_decide (
  input  logic              clk,
  input  logic              rst_n,
  input  fdmd_pkg::cfg_t    cfg,
  input  logic              done,
  input  logic              first,
  input  logic [20:0]       count,
  output logic              busy,
  fdmd_res_if.source        res_o
);
  typedef enum logic [2:0] {D_IDLE, D_MUL1, D_MUL2, D_CMP, D_OUT} state_t;
  state_t state_r;
  logic [31:0] frame_r;
  logic        active_r;
  logic [7:0]  mv_r, st_r;
  logic [35:0] lhs_r;
  logic [24:0] wh_r;
  logic [38:0] rhs_r;
  logic        first_r;
  logic [20:0] cnt_r;
  logic [10:0] w, h;
  assign w = fdmd_pkg::eff_size(cfg.line_len, 11'(fdmd_pkg::MaxWidth));
  assign h = fdmd_pkg::eff_size(cfg.line_count, 11'(fdmd_pkg::MaxHeight));

  logic now;
  assign now = !first_r && ({3'd0, lhs_r} >= rhs_r);
  logic [7:0] mv_inc, st_inc;
  assign mv_inc = (mv_r == 8'hFF) ? mv_r : mv_r + 8'd1;
  assign st_inc = (st_r == 8'hFF) ? st_r : st_r + 8'd1;

  assign busy = (state_r != D_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE; frame_r <= '0; active_r <= 1'b0; mv_r <= '0; st_r <= '0;
      res_o.valid <= 1'b0;
    end else begin
      unique case (state_r)
        D_IDLE: if (done) begin
          first_r <= first; cnt_r <= count;
          state_r <= D_MUL1;
        end
        D_MUL1: begin
          lhs_r <= 36'(cnt_r) * 36'd10000;
          wh_r <= 25'(w) * 25'(h);
          state_r <= D_MUL2;
        end
        D_MUL2: begin
          rhs_r <= 39'(wh_r) * 39'(cfg.share_thresh);
          state_r <= D_CMP;
        end
        D_CMP: begin
          res_o.res.frame_number <= frame_r;
          res_o.res.first_frame <= first_r;
          res_o.res.changed_count <= cnt_r;
          res_o.res.motion_now <= now;
          res_o.res.motion_rise <= 1'b0;
          res_o.res.motion_fall <= 1'b0;
          res_o.res.motion_state <= active_r;
          if (!first_r) begin
            if (!active_r) begin
              if (now) begin
                if (mv_inc >= cfg.start_frames) begin
                  active_r <= 1'b1; mv_r <= '0;
                  res_o.res.motion_rise <= 1'b1; res_o.res.motion_state <= 1'b1;
                end else mv_r <= mv_inc;
              end else mv_r <= '0;
            end else begin
              if (!now) begin
                if (st_inc >= cfg.end_frames) begin
                  active_r <= 1'b0; st_r <= '0;
                  res_o.res.motion_fall <= 1'b1; res_o.res.motion_state <= 1'b0;
                end else st_r <= st_inc;
              end else st_r <= '0;
            end
          end
          frame_r <= frame_r + 32'd1;
          res_o.valid <= 1'b1;
          state_r <= D_OUT;
        end
        D_OUT: if (res_o.ready) begin
          res_o.valid <= 1'b0;
          state_r <= D_IDLE;
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end
endmodule

@@ hdl/frame_difference_motion_detector.sv @@
// Frame-difference motion detector, top level.
// Pixels: one per cycle while a frame streams in. After a frame's last pixel the engine
// sweeps the planes (diff, blur, erode, dilate), issuing each memory read and capturing it in
// the next phase, diff only for the first frame; the result word then passes the multiply and
// compare states. Input is stalled during the sweep and until the result is taken.
// Reset (rst_n, synchronous): registers to defaults, counters cleared, memories kept.
module frame_difference_motion_detector (
  input  logic        clk,
  input  logic        rst_n,
  fdmd_pix_if.sink    in_ch,
  fdmd_res_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  fdmd_pkg::cfg_t cfg_r;
  logic wr;
  logic [2:0] idx;
  assign cfg_pready = 1'b1;
  assign wr  = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx = cfg_paddr[4:2];

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_len <= 11'd640; cfg_r.line_count <= 11'd480;
      cfg_r.share_thresh <= 14'd100; cfg_r.start_frames <= 8'd2;
      cfg_r.end_frames <= 8'd3; cfg_r.pixel_threshold <= 8'd30;
    end else if (wr) begin
      unique case (idx)
        fdmd_pkg::RegWidth:  cfg_r.line_len <= cfg_pwdata[10:0];
        fdmd_pkg::RegHeight: cfg_r.line_count <= cfg_pwdata[10:0];
        fdmd_pkg::RegThresh: cfg_r.share_thresh <= cfg_pwdata[13:0];
        fdmd_pkg::RegStart:  cfg_r.start_frames <= cfg_pwdata[7:0];
        fdmd_pkg::RegEnd:    cfg_r.end_frames <= cfg_pwdata[7:0];
        fdmd_pkg::RegPixTh:  cfg_r.pixel_threshold <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      fdmd_pkg::RegWidth:  cfg_prdata = 32'(cfg_r.line_len);
      fdmd_pkg::RegHeight: cfg_prdata = 32'(cfg_r.line_count);
      fdmd_pkg::RegThresh: cfg_prdata = 32'(cfg_r.share_thresh);
      fdmd_pkg::RegStart:  cfg_prdata = 32'(cfg_r.start_frames);
      fdmd_pkg::RegEnd:    cfg_prdata = 32'(cfg_r.end_frames);
      fdmd_pkg::RegPixTh:  cfg_prdata = 32'(cfg_r.pixel_threshold);
      default:             cfg_prdata = 32'd0;
    endcase
  end

  logic size_wr;
  assign size_wr = wr && (idx == fdmd_pkg::RegWidth || idx == fdmd_pkg::RegHeight);

  logic core_rdy, done, first, busy;
  logic [20:0] count;

  // core sees only accepted pixels
  fdmd_core u_core (
    .clk, .rst_n, .cfg(cfg_r), .size_wr,
    .pix_valid(in_ch.valid && in_ch.ready), .pix_ready(core_rdy), .pix_luma(in_ch.luma),
    .done, .first, .count
  );
  // hold off input while a result is in flight
  assign in_ch.ready = core_rdy && !busy && !done;

  fdmd_decide u_dec (
    .clk, .rst_n, .cfg(cfg_r), .done, .first, .count, .busy, .res_o(out_ch)
  );

  a_no_in_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ch.ready) else $error("input accepted during decision");
  a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.res.first_frame |-> out_ch.res.changed_count == 21'd0)
    else $error("first frame with nonzero count");
  a_on_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.res.motion_rise && out_ch.res.motion_fall))
    else $error("motion rise and fall together");
endmodule
